>>> sv/assert_macros.svh
// Assertion macros used by the sorter top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_ALWAYS(lbl, clk, rst_n, expr) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
		else $error("invariant violated");
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");
`else
`define ASSERT_ALWAYS(lbl, clk, rst_n, expr)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

>>> sv/lps_pkg.sv
package lps_pkg;

	localparam int COORD_W = 32;
	localparam int KEY_W   = 3 * COORD_W;
	localparam int IDX_W   = 8;
	localparam int ARR_W   = 9;

	localparam logic [COORD_W-1:0] SIGN_FLIP = {1'b1, {(COORD_W-1){1'b0}}};

	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_READ = 1'b1;

	typedef enum logic [1:0] {
		ST_LOAD_OK    = 2'd0,
		ST_READ_OK    = 2'd1,
		ST_LOAD_FULL  = 2'd2,
		ST_READ_EMPTY = 2'd3
	} status_t;

	typedef logic [KEY_W-1:0] key_t;

	typedef struct packed {
		logic                      operation;
		logic signed [COORD_W-1:0] coord_x;
		logic signed [COORD_W-1:0] coord_y;
		logic signed [COORD_W-1:0] coord_z;
	} req_t;

	typedef struct packed {
		logic [IDX_W-1:0] sorted_index;
		logic             last_of_run;
		status_t          status;
	} rsp_t;

	typedef struct packed {
		key_t             key;
		logic [IDX_W-1:0] idx;
	} entry_t;

	typedef struct packed {
		logic insert;
		logic pop;
	} cell_ctl_t;

endpackage

>>> sv/lps_stream_if.sv
interface lps_stream_if #(
	parameter type T = logic
) ();
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

>>> sv/lexicographic_position_sorter_top.sv
// Channel | Modport | Payload                                  | Transaction
// req     | sink    | operation, coord_x, coord_y, coord_z     | one load or read
// rsp     | source  | sorted_index, last_of_run, status        | one result per req
//
// All cells compare an accepted key with their own in parallel; the chain shifts in
// the cycle of acceptance, so one item per cycle while req.ready stays high.
// Each result is registered into a two-entry output buffer (main and skid) feeding rsp.
// req.ready drops only while both buffer entries hold results that rsp has not taken.
// Reset clears the occupancy and arrival counters; cell contents need no clearing.
`include "assert_macros.svh"

module lexicographic_position_sorter_top #(
	parameter int CAPACITY = 256
) (
	input  logic         clk,
	input  logic         arst_n,
	lps_stream_if.sink   req,
	lps_stream_if.source rsp
);
	import lps_pkg::*;

	localparam int CW = $clog2(CAPACITY + 1);

	logic              acc;
	logic              is_load;
	logic              full;
	logic              empty;
	logic              ins;
	logic              pop;
	logic              space;
	logic [CW-1:0]     count_q;
	logic [ARR_W-1:0]  arrival_q;
	cell_ctl_t         ctl;
	entry_t            new_entry;
	entry_t            cell_entry [CAPACITY];
	logic              cell_gt    [CAPACITY];
	rsp_t              result;

	assign req.ready = space;
	assign acc       = req.valid && req.ready;
	assign is_load   = (req.data.operation == OP_LOAD);
	assign full      = (count_q == CW'(CAPACITY));
	assign empty     = (count_q == '0);
	assign ins       = acc && is_load && !full;
	assign pop       = acc && !is_load && !empty;

	assign ctl.insert = ins;
	assign ctl.pop    = pop;

	// Flipping the sign bits lets one unsigned compare order signed coordinates.
	assign new_entry.key = {req.data.coord_x ^ SIGN_FLIP,
	                        req.data.coord_y ^ SIGN_FLIP,
	                        req.data.coord_z ^ SIGN_FLIP};
	assign new_entry.idx = arrival_q[IDX_W-1:0];

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		entry_t left_e;
		entry_t right_e;
		logic   left_g;

		if (i == 0) begin : g_head
			assign left_e = new_entry;
			assign left_g = 1'b0;
		end else begin : g_body
			assign left_e = cell_entry[i-1];
			assign left_g = cell_gt[i-1];
		end

		if (i == CAPACITY - 1) begin : g_tail
			assign right_e = cell_entry[i];
		end else begin : g_next
			assign right_e = cell_entry[i+1];
		end

		lps_cell u_cell (
			.clk        (clk),
			.occupied   (count_q > CW'(i)),
			.ctl        (ctl),
			.new_entry  (new_entry),
			.left_entry (left_e),
			.left_gt    (left_g),
			.right_entry(right_e),
			.entry      (cell_entry[i]),
			.gt         (cell_gt[i])
		);
	end

	always_comb begin
		result.sorted_index = '0;
		result.last_of_run  = 1'b0;
		if (is_load) begin
			result.status = full ? ST_LOAD_FULL : ST_LOAD_OK;
			if (!full) begin
				result.sorted_index = arrival_q[IDX_W-1:0];
			end
		end else begin
			result.status = empty ? ST_READ_EMPTY : ST_READ_OK;
			if (!empty) begin
				result.sorted_index = cell_entry[0].idx;
				result.last_of_run  = (count_q == CW'(1));
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			arrival_q <= '0;
		end else if (ins) begin
			count_q   <= count_q + CW'(1);
			arrival_q <= arrival_q + ARR_W'(1);
		end else if (pop) begin
			count_q <= count_q - CW'(1);
			if (count_q == CW'(1)) begin
				arrival_q <= '0;
			end
		end
	end

	lps_out_buf u_out_buf (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (acc),
		.push_data(result),
		.space    (space),
		.rsp      (rsp)
	);

	`ASSERT_ALWAYS(a_count_bound, clk, arst_n, count_q <= CW'(CAPACITY))
	`ASSERT_NEXT(a_load_grows, clk, arst_n, ins, count_q == $past(count_q) + CW'(1))
	`ASSERT_NEXT(a_full_holds, clk, arst_n, acc && is_load && full, count_q == CW'(CAPACITY))
	`ASSERT_NEXT(a_empty_restart, clk, arst_n, pop && count_q == CW'(1), arrival_q == '0 && count_q == '0)

endmodule

>>> sv/lps_cell.sv
module lps_cell (
	input  logic              clk,
	input  logic              occupied,
	input  lps_pkg::cell_ctl_t ctl,
	input  lps_pkg::entry_t   new_entry,
	input  lps_pkg::entry_t   left_entry,
	input  logic              left_gt,
	input  lps_pkg::entry_t   right_entry,
	output lps_pkg::entry_t   entry,
	output logic              gt
);
	import lps_pkg::*;

	entry_t entry_q;

	// An empty cell counts as greater, so a key no smaller than every stored key lands after them.
	assign gt    = !occupied || (entry_q.key > new_entry.key);
	assign entry = entry_q;

	always_ff @(posedge clk) begin
		if (ctl.insert && gt) begin
			entry_q <= left_gt ? left_entry : new_entry;
		end else if (ctl.pop) begin
			entry_q <= right_entry;
		end
	end

endmodule

>>> sv/lps_out_buf.sv
module lps_out_buf (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  lps_pkg::rsp_t push_data,
	output logic          space,
	lps_stream_if.source  rsp
);
	import lps_pkg::*;

	logic main_valid_q;
	logic skid_valid_q;
	rsp_t main_q;
	rsp_t skid_q;
	logic drain;

	assign drain     = main_valid_q && rsp.ready;
	assign space     = !skid_valid_q;
	assign rsp.valid = main_valid_q;
	assign rsp.data  = main_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (!main_valid_q || drain) begin
			main_valid_q <= skid_valid_q || push;
			skid_valid_q <= skid_valid_q && push;
		end else begin
			skid_valid_q <= skid_valid_q || push;
		end
	end

	always_ff @(posedge clk) begin
		if (!main_valid_q || drain) begin
			main_q <= skid_valid_q ? skid_q : push_data;
		end
		if (push) begin
			skid_q <= push_data;
		end
	end

endmodule

>>> sim/lexicographic_position_sorter_top_test.sv
module lexicographic_position_sorter_top_test;
	timeunit 1ns;
	timeprecision 1ps;

	import lps_pkg::*;

	localparam int DEPTH = 256;
	localparam int ITEM_TARGET = 1600;
	localparam logic signed [COORD_W-1:0] CMIN = 32'sh8000_0000;
	localparam logic signed [COORD_W-1:0] CMAX = 32'sh7FFF_FFFF;
	localparam int DIR_N = 23;

	typedef enum int {RX_OPEN, RX_HALF, RX_MOSTLY, RX_CHOKED} rx_mode_t;

	typedef struct packed {
		req_t item;
		bit   typed;
		rsp_t want;
	} dir_row_t;

	logic clk = 1'b0;
	logic arst_n;

	lps_stream_if #(.T(req_t)) req_ch ();
	lps_stream_if #(.T(rsp_t)) rsp_ch ();

	lexicographic_position_sorter_top #(.CAPACITY(DEPTH)) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch.sink),
		.rsp    (rsp_ch.source)
	);

	always #2 clk = ~clk;

	logic signed [COORD_W-1:0] held_x [DEPTH];
	logic signed [COORD_W-1:0] held_y [DEPTH];
	logic signed [COORD_W-1:0] held_z [DEPTH];
	logic [IDX_W-1:0]          held_id [DEPTH];
	int                        held = 0;
	logic [ARR_W-1:0]          arrival = '0;

	rsp_t     pending_results [$];
	int       mismatch_count = 0;
	int       sent_count = 0;
	int       burst_left = 0;
	rx_mode_t rx_mode = RX_OPEN;
	int       rx_left = 0;
	dir_row_t dir_rows [DIR_N];

	function automatic bit key_le(input logic signed [COORD_W-1:0] ax, ay, az, bx, by, bz);
		if (ax != bx) return ax < bx;
		if (ay != by) return ay < by;
		return az <= bz;
	endfunction

	function automatic rsp_t next_sort_result(input req_t rq);
		rsp_t r;
		int p;
		r = '{sorted_index: '0, last_of_run: 1'b0, status: ST_LOAD_OK};
		if (rq.operation == OP_LOAD) begin
			if (held == DEPTH) begin
				r.status = ST_LOAD_FULL;
			end else begin
				p = 0;
				while (p < held && key_le(held_x[p], held_y[p], held_z[p],
						rq.coord_x, rq.coord_y, rq.coord_z))
					p++;
				for (int i = held; i > p; i--) begin
					held_x[i] = held_x[i-1];
					held_y[i] = held_y[i-1];
					held_z[i] = held_z[i-1];
					held_id[i] = held_id[i-1];
				end
				held_x[p] = rq.coord_x;
				held_y[p] = rq.coord_y;
				held_z[p] = rq.coord_z;
				held_id[p] = arrival[IDX_W-1:0];
				held++;
				r.sorted_index = arrival[IDX_W-1:0];
				arrival = arrival + 1'b1;
			end
		end else if (held == 0) begin
			r.status = ST_READ_EMPTY;
		end else begin
			r.sorted_index = held_id[0];
			for (int i = 1; i < held; i++) begin
				held_x[i-1] = held_x[i];
				held_y[i-1] = held_y[i];
				held_z[i-1] = held_z[i];
				held_id[i-1] = held_id[i];
			end
			held--;
			r.status = ST_READ_OK;
			if (held == 0) begin
				r.last_of_run = 1'b1;
				arrival = '0;
			end
		end
		return r;
	endfunction

	function automatic logic signed [COORD_W-1:0] pick_coord();
		case ($urandom_range(0, 7))
			0: return CMIN;
			1: return CMAX;
			2, 3: return $urandom;
			default: return $signed(32'($urandom_range(0, 4))) - 32'sd2;
		endcase
	endfunction

	task automatic issue_request(input req_t rq, input bit typed, input rsp_t typed_rsp);
		rsp_t want;
		if (burst_left == 0) begin
			req_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 250)
				: $urandom_range(1, 24);
		end
		req_ch.valid <= 1'b1;
		req_ch.data <= rq;
		do @(posedge clk); while (!req_ch.ready);
		burst_left--;
		want = next_sort_result(rq);
		pending_results.push_back(typed ? typed_rsp : want);
		sent_count++;
	endtask

	task automatic send_random(input logic op);
		req_t rq;
		rq.operation = op;
		rq.coord_x = pick_coord();
		rq.coord_y = pick_coord();
		rq.coord_z = pick_coord();
		issue_request(rq, 1'b0, '0);
	endtask

	task automatic hold_until_drained();
		req_ch.valid <= 1'b0;
		burst_left = 0;
		do @(posedge clk); while (pending_results.size() != 0);
	endtask

	always @(posedge clk) begin
		if (rx_left == 0) begin
			rx_mode = rx_mode_t'($urandom_range(0, 3));
			rx_left = $urandom_range(16, 96);
		end
		rx_left--;
		case (rx_mode)
			RX_OPEN: rsp_ch.ready <= 1'b1;
			RX_HALF: rsp_ch.ready <= ($urandom_range(0, 1) == 1);
			RX_MOSTLY: rsp_ch.ready <= ($urandom_range(0, 7) != 0);
			default: rsp_ch.ready <= ((rx_left % 24) < 4);
		endcase
	end

	always @(posedge clk) begin
		rsp_t want;
		rsp_t got;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			got = rsp_ch.data;
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected transaction, got index %0d last %0d status %0d",
					$time, got.sorted_index, got.last_of_run, got.status);
				mismatch_count++;
			end else begin
				want = pending_results.pop_front();
				if (got.sorted_index !== want.sorted_index) begin
					$display("%0t: sorted_index expected %0d, got %0d",
						$time, want.sorted_index, got.sorted_index);
					mismatch_count++;
				end
				if (got.last_of_run !== want.last_of_run) begin
					$display("%0t: last_of_run expected %0d, got %0d",
						$time, want.last_of_run, got.last_of_run);
					mismatch_count++;
				end
				if (got.status !== want.status) begin
					$display("%0t: status expected %0d, got %0d",
						$time, want.status, got.status);
					mismatch_count++;
				end
			end
		end
	end

	initial begin
		#2ms;
		$display("lexicographic_position_sorter_top verification failed");
		$finish;
	end

	initial begin
		logic op;
		int k;
		req_ch.valid = 1'b0;
		req_ch.data = '0;
		rsp_ch.ready = 1'b0;
		arst_n = 1'b0;
		dir_rows = '{
			'{'{OP_READ, 32'sd0, 32'sd0, 32'sd0}, 1'b1, '{8'd0, 1'b0, ST_READ_EMPTY}},
			'{'{OP_LOAD, CMIN, CMIN, CMIN}, 1'b1, '{8'd0, 1'b0, ST_LOAD_OK}},
			'{'{OP_LOAD, CMAX, CMAX, CMAX}, 1'b1, '{8'd1, 1'b0, ST_LOAD_OK}},
			'{'{OP_LOAD, 32'sd0, 32'sd0, 32'sd0}, 1'b1, '{8'd2, 1'b0, ST_LOAD_OK}},
			'{'{OP_LOAD, 32'sd0, 32'sd0, 32'sd0}, 1'b1, '{8'd3, 1'b0, ST_LOAD_OK}},
			'{'{OP_LOAD, 32'sd0, 32'sd0, -32'sd1}, 1'b1, '{8'd4, 1'b0, ST_LOAD_OK}},
			'{'{OP_LOAD, 32'sd0, -32'sd1, CMAX}, 1'b1, '{8'd5, 1'b0, ST_LOAD_OK}},
			'{'{OP_LOAD, -32'sd1, CMAX, CMAX}, 1'b1, '{8'd6, 1'b0, ST_LOAD_OK}},
			'{'{OP_LOAD, CMIN, CMIN, CMIN}, 1'b1, '{8'd7, 1'b0, ST_LOAD_OK}},
			'{'{OP_READ, 32'sd0, 32'sd0, 32'sd0}, 1'b0, '0},
			'{'{OP_READ, 32'sd0, 32'sd0, 32'sd0}, 1'b0, '0},
			'{'{OP_READ, 32'sd0, 32'sd0, 32'sd0}, 1'b0, '0},
			'{'{OP_READ, 32'sd0, 32'sd0, 32'sd0}, 1'b0, '0},
			'{'{OP_READ, 32'sd0, 32'sd0, 32'sd0}, 1'b0, '0},
			'{'{OP_READ, 32'sd0, 32'sd0, 32'sd0}, 1'b0, '0},
			'{'{OP_READ, 32'sd0, 32'sd0, 32'sd0}, 1'b0, '0},
			'{'{OP_READ, 32'sd0, 32'sd0, 32'sd0}, 1'b0, '0},
			'{'{OP_READ, 32'sd0, 32'sd0, 32'sd0}, 1'b1, '{8'd0, 1'b0, ST_READ_EMPTY}},
			'{'{OP_LOAD, CMAX, CMIN, 32'sd0}, 1'b1, '{8'd0, 1'b0, ST_LOAD_OK}},
			'{'{OP_READ, CMAX, CMAX, CMAX}, 1'b1, '{8'd0, 1'b1, ST_READ_OK}},
			'{'{OP_READ, CMIN, 32'sh5555_5555, -32'sd1}, 1'b1, '{8'd0, 1'b0, ST_READ_EMPTY}},
			'{'{OP_LOAD, 32'sh5555_5555, 32'shAAAA_AAAA, 32'sh0F0F_F0F0}, 1'b1,
				'{8'd0, 1'b0, ST_LOAD_OK}},
			'{'{OP_READ, 32'sd0, 32'sd0, 32'sd0}, 1'b1, '{8'd0, 1'b1, ST_READ_OK}}
		};
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < DIR_N; i++)
			issue_request(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].want);
		hold_until_drained();

		repeat (300) send_random(($urandom_range(0, 99) < 55) ? OP_LOAD : OP_READ);
		hold_until_drained();

		// Fill the store with a little read noise, then push loads into the full store.
		while (held < DEPTH)
			send_random(($urandom_range(0, 15) == 0) ? OP_READ : OP_LOAD);
		repeat (12) send_random(OP_LOAD);

		// Churning near capacity drives the arrival counter past its wrap point.
		repeat (600) begin
			if (held >= DEPTH - 2)
				op = ($urandom_range(0, 9) < 6) ? OP_READ : OP_LOAD;
			else
				op = ($urandom_range(0, 9) < 7) ? OP_LOAD : OP_READ;
			send_random(op);
		end
		while (held > 0)
			send_random(OP_READ);
		repeat (5) send_random(OP_READ);
		hold_until_drained();

		while (sent_count < ITEM_TARGET) begin
			k = $urandom_range(1, 8);
			repeat (k) send_random(OP_LOAD);
			repeat (k + $urandom_range(0, 1)) send_random(OP_READ);
		end
		hold_until_drained();
		repeat (8) @(posedge clk);

		if (mismatch_count == 0) begin
			$display("lexicographic_position_sorter_top verification clean");
		end else begin
			$display("lexicographic_position_sorter_top verification failed");
		end
		$finish;
	end
endmodule
